/* src/ssi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg: shared constants for the scalar span interpolator
// Field widths, the default span length and the serial divider step count.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // Q16.16 value width and count field width
  localparam int VAL_W    = 32;
  localparam int CNT_IN_W = 7;

  // default longest span
  localparam int MAX_COUNT_DEF = 64;

  // serial divide: one quotient bit per cycle over the 33-bit difference
  localparam int DIV_STEPS = VAL_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

/* src/scalar_span_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_span_interpolator: linear interpolation over a span in Q16.16
// Emits count evenly spaced values from start toward end, last one flagged.
// ----------------------------------------------------------------------------
// An item with count N (saturated to MAX_COUNT) is taken with no output
// when N is 0. For N of 1 the midpoint is loaded when the item is taken. For N
// of 2 or more the step (end-start)/(N-1) comes from a restoring divider that
// produces one quotient bit per cycle over the 33-bit difference, then a sign
// step that restores the sign, then one value per cycle while the output
// side takes them. The input side is ready only between items; the output
// register lets the next item be taken while the final value of a span still
// waits to be taken.
module scalar_span_interpolator
  import ssi_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [VAL_W-1:0]    start_value_i,
  input  logic signed [VAL_W-1:0]    end_value_i,
  input  logic        [CNT_IN_W-1:0] count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [VAL_W-1:0]    value_o,
  output logic                       last_o
);

  localparam int CNT_W = $clog2(MAX_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   left_q;
  logic [CNT_W-1:0]   div_q;
  logic [CNT_W-1:0]   rem_q;
  logic [VAL_W:0]     quo_q;
  logic               neg_q;
  logic [DIV_CNT_W-1:0] bit_cnt_q;
  logic [VAL_W-1:0]   cur_q;
  logic [VAL_W-1:0]   step_q;
  logic               out_valid_q;
  logic [VAL_W-1:0]   value_q;
  logic               last_q;

  // input side
  logic             in_acc;
  logic [CNT_W-1:0] n_sat;
  logic [VAL_W:0]   diff;
  logic [VAL_W:0]   diff_mag;
  logic [VAL_W:0]   mid_sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign n_sat = (count_i > CNT_IN_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                  : CNT_W'(count_i);

  // exact 33-bit difference, its magnitude, and the midpoint sum
  assign diff     = {end_value_i[VAL_W-1], end_value_i}
                  - {start_value_i[VAL_W-1], start_value_i};
  assign diff_mag = diff[VAL_W] ? (~diff + 1'b1) : diff;
  assign mid_sum  = {start_value_i[VAL_W-1], start_value_i}
                  + {end_value_i[VAL_W-1], end_value_i};

  // one restoring divide step
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   trial_sub;
  logic             trial_ge;

  assign trial     = {rem_q, quo_q[VAL_W]};
  assign trial_sub = trial - {1'b0, div_q};
  assign trial_ge  = (trial >= {1'b0, div_q});

  // output slot can take a new value
  logic slot_free;
  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer, divider and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      cur_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            left_q    <= n_sat;
            div_q     <= n_sat - 1'b1;
            rem_q     <= '0;
            quo_q     <= diff_mag;
            neg_q     <= diff[VAL_W];
            bit_cnt_q <= '0;
            if (n_sat == CNT_W'(1)) begin
              cur_q   <= mid_sum[VAL_W:1];
              state_q <= ST_EMIT;
            end else if (n_sat != '0) begin
              cur_q   <= start_value_i;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q     <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
          quo_q     <= {quo_q[VAL_W-1:0], trial_ge};
          bit_cnt_q <= bit_cnt_q + 1'b1;
          if (bit_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          // step kept modulo 2^32; every running sum lands in range
          step_q  <= neg_q ? (~quo_q[VAL_W-1:0] + 1'b1) : quo_q[VAL_W-1:0];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            value_q     <= cur_q;
            last_q      <= (left_q == CNT_W'(1));
            cur_q       <= cur_q + step_q;
            left_q      <= left_q - 1'b1;
            if (left_q == CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  // divider never runs with a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_q != '0))
    else $error("divider running with zero divisor");

  // emit phase always has values left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (left_q != '0))
    else $error("emit phase with empty span");

  // sign fixup follows the final divide step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |->
      ($past(state_q) == ST_DIV) && ($past(bit_cnt_q) == DIV_CNT_W'(DIV_STEPS - 1)))
    else $error("sign fixup without a full divide");

  // a span of two or more values enters the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (n_sat > CNT_W'(1))) |=> (state_q == ST_DIV) && (bit_cnt_q == '0))
    else $error("multi-value span did not start a divide");

  // leaving the emit phase coincides with loading a last value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) ##1 (state_q == ST_IDLE) |-> out_valid_q && last_q)
    else $error("span ended without a last value");

endmodule

/* verif/ssi_span_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_span_checker: scoreboard for the scalar span interpolator
// Watches both channels, predicts the Q16.16 span of each accepted item and
// compares every accepted output value, in order, against that prediction.
// ----------------------------------------------------------------------------
module ssi_span_checker
  import ssi_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [VAL_W-1:0]    start_value_i,
  input  logic signed [VAL_W-1:0]    end_value_i,
  input  logic        [CNT_IN_W-1:0] count_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [VAL_W-1:0]    value_i,
  input  logic                       last_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } span_point_t;

  span_point_t span_points_q[$];
  int          fails = 0;
  int          shown = 0;

  // Expand one item into the values the block should emit
  function automatic void predict_span(input logic signed [VAL_W-1:0] a_raw,
                                       input logic signed [VAL_W-1:0] b_raw,
                                       input logic [CNT_IN_W-1:0]     n_raw);
    longint      a;
    longint      b;
    longint      step;
    longint      cur;
    int          n;
    span_point_t pt;
    a = a_raw;
    b = b_raw;
    n = (n_raw > MAX_COUNT) ? MAX_COUNT : int'(n_raw);
    if (n == 1) begin
      // midpoint with a flooring shift; the sum is exact in 64 bits
      pt.value = VAL_W'((a + b) >>> 1);
      pt.last  = 1'b1;
      span_points_q.push_back(pt);
    end else if (n >= 2) begin
      // signed division truncates toward zero
      step = (b - a) / longint'(n - 1);
      cur  = a;
      for (int k = 0; k < n; k++) begin
        pt.value = VAL_W'(cur);
        pt.last  = (k == n - 1);
        span_points_q.push_back(pt);
        cur += step;
      end
    end
  endfunction

  // Sample both channels on the clock edge
  always @(posedge clk_i) begin
    span_point_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        predict_span(start_value_i, end_value_i, count_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (span_points_q.size() == 0) begin
          fails++;
          if (shown < 10) begin
            shown++;
            $display("%0t: unexpected output item value %h last %b",
                     $time, value_i, last_i);
          end
        end else begin
          want = span_points_q.pop_front();
          if (want.value !== value_i || want.last !== last_i) begin
            fails++;
            if (shown < 10) begin
              shown++;
              $display("%0t: mismatch value exp %h got %h, last exp %b got %b",
                       $time, want.value, value_i, want.last, last_i);
            end
          end
        end
      end
    end
    pending_o    <= span_points_q.size();
    fail_count_o <= fails;
  end

endmodule

/* verif/tb_scalar_span_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_span_interpolator: testbench for the scalar span interpolator
// Drives directed and random spans with random gaps on both channels; the
// span checker predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_scalar_span_interpolator;
  import ssi_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int                      RANDOM_ITEMS = 350;
  localparam int                      SEG_ITEMS = 50;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [VAL_W-1:0]    start_value = '0;
  logic signed [VAL_W-1:0]    end_value = '0;
  logic        [CNT_IN_W-1:0] count = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [VAL_W-1:0]    value;
  logic                       last;
  int                         fail_count;
  int                         pending;

  // burst flags: when set, that side never idles
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  scalar_span_interpolator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .start_value_i (start_value),
    .end_value_i   (end_value),
    .count_i       (count),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .value_o       (value),
    .last_o        (last)
  );

  ssi_span_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .start_value_i (start_value),
    .end_value_i   (end_value),
    .count_i       (count),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .value_i       (value),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: ends the run with an error if it hangs
  initial begin
    #20_000_000;
    $display("[scalar_span_interpolator] ERROR");
    $finish;
  end

  // Offer one item after a random gap, hold it until accepted
  task automatic send_span(input logic signed [VAL_W-1:0] a,
                           input logic signed [VAL_W-1:0] b,
                           input logic [CNT_IN_W-1:0]     n);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    start_value <= a;
    end_value   <= b;
    count       <= n;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Hold off the sender until every expected value has come out
  task automatic drain_spans();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Endpoint mix: full range, small magnitudes, extremes
  function automatic logic signed [VAL_W-1:0] pick_endpoint();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return $signed(VAL_W'($urandom_range(0, 2 ** 21))) - 32'sd1048576;
      3:       return VAL_MIN + $urandom_range(0, 255);
      4:       return VAL_MAX - $urandom_range(0, 255);
      default: return $signed(VAL_W'($urandom_range(0, 16))) - 32'sd8;
    endcase
  endfunction

  // Counts: mostly short spans, some long, some above the saturation limit
  function automatic logic [CNT_IN_W-1:0] pick_count();
    case ($urandom_range(0, 19))
      0, 1:        return '0;
      2, 3:        return 7'd1;
      4, 5, 6:     return CNT_IN_W'($urandom_range(MAX_COUNT_DEF - 2, 127));
      7, 8, 9:     return CNT_IN_W'($urandom_range(17, MAX_COUNT_DEF));
      default:     return CNT_IN_W'($urandom_range(2, 16));
    endcase
  endfunction

  // Output side: random stall before each item, none during bursts
  initial begin : take_proc
    int stall;
    wait (rst_ni);
    forever begin
      stall = take_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin : stim_proc
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: endpoints at the extremes, each count regime
    send_span('0, '0, 7'd0);
    send_span(VAL_MIN, VAL_MAX, 7'd0);
    send_span(VAL_MIN, VAL_MAX, 7'd1);
    send_span(VAL_MIN, VAL_MIN, 7'd1);
    send_span(VAL_MAX, VAL_MAX, 7'd1);
    send_span(-32'sd1, 32'sd0, 7'd1);
    send_span(32'sd3, -32'sd4, 7'd1);
    send_span(VAL_MIN, VAL_MAX, 7'd2);
    send_span(VAL_MAX, VAL_MIN, 7'd2);
    send_span(VAL_MIN, VAL_MAX, 7'd64);
    send_span(VAL_MAX, VAL_MIN, 7'd64);
    send_span(32'sd0, 32'sd10, 7'd3);
    send_span(32'sd0, -32'sd10, 7'd3);
    // truncation toward zero, both signs; end is not reached
    send_span(32'sd0, 32'sd7, 7'd3);
    send_span(32'sd0, -32'sd7, 7'd3);
    send_span(32'sd1, 32'sd64, 7'd64);
    send_span(32'sh0005_0000, 32'sh0005_0000, 7'd10);
    // counts above the limit saturate
    send_span(VAL_MIN, VAL_MAX, 7'd65);
    send_span(32'sh0001_0000, -32'sh0003_8000, 7'd127);
    send_span($urandom, $urandom, 7'd100);
    send_span('1, VAL_MAX, 7'd63);
    send_span($urandom, $urandom, 7'd0);
    drain_spans();

    // random segments with varying idle patterns
    for (int seg = 0; seg < RANDOM_ITEMS / SEG_ITEMS; seg++) begin
      send_burst = ($urandom_range(0, 2) == 0);
      take_burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        a = pick_endpoint();
        case ($urandom_range(0, 5))
          0:       b = a;
          1:       b = a + $signed(VAL_W'($urandom_range(0, 200))) - 32'sd100;
          default: b = pick_endpoint();
        endcase
        send_span(a, b, pick_count());
      end
      if (seg % 2 == 1) drain_spans();
    end
    send_burst = 1'b0;
    take_burst = 1'b0;

    // wait for the tail, then give the block time to show stray values
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[scalar_span_interpolator] OK");
    end else begin
      $display("[scalar_span_interpolator] ERROR");
    end
    $finish;
  end

endmodule
